/* design/csubtok_pkg.sv */
// Shared types, token and error codes and character-class helpers for the C subset tokenizer.
package csubtok_pkg;

    localparam int unsigned MAX_INPUT_BYTES_DEF = 1048576;
    localparam int unsigned MAX_TOKEN_LEN_DEF   = 256;
    localparam int unsigned MAX_NESTING_DEF     = 15;

    localparam logic [20:0] LINE_MAX = 21'h1FFFFF;

    // token kinds
    localparam logic [6:0] K_EOF     = 7'd0;
    localparam logic [6:0] K_IDENT   = 7'd1;
    localparam logic [6:0] K_INT     = 7'd2;
    localparam logic [6:0] K_FLOAT   = 7'd3;
    localparam logic [6:0] K_CHAR    = 7'd4;
    localparam logic [6:0] K_STR     = 7'd5;
    localparam logic [6:0] K_COLON   = 7'd6;
    localparam logic [6:0] K_LPAREN  = 7'd7;
    localparam logic [6:0] K_RPAREN  = 7'd8;
    localparam logic [6:0] K_LBRACE  = 7'd9;
    localparam logic [6:0] K_RBRACE  = 7'd10;
    localparam logic [6:0] K_LBRACK  = 7'd11;
    localparam logic [6:0] K_RBRACK  = 7'd12;
    localparam logic [6:0] K_COMMA   = 7'd13;
    localparam logic [6:0] K_DOT     = 7'd14;
    localparam logic [6:0] K_SEMI    = 7'd16;
    localparam logic [6:0] K_OROR1   = 7'd18;
    localparam logic [6:0] K_AND1    = 7'd19;
    localparam logic [6:0] K_PLUS    = 7'd22;
    localparam logic [6:0] K_MINUS   = 7'd23;
    localparam logic [6:0] K_STAR    = 7'd24;
    localparam logic [6:0] K_SLASH   = 7'd25;
    localparam logic [6:0] K_MOD     = 7'd26;
    localparam logic [6:0] K_EQEQ    = 7'd27;
    localparam logic [6:0] K_NE      = 7'd28;
    localparam logic [6:0] K_LT      = 7'd29;
    localparam logic [6:0] K_GT      = 7'd30;
    localparam logic [6:0] K_LE      = 7'd31;
    localparam logic [6:0] K_GE      = 7'd32;
    localparam logic [6:0] K_INC     = 7'd33;
    localparam logic [6:0] K_DEC     = 7'd34;
    localparam logic [6:0] K_NOT     = 7'd35;
    localparam logic [6:0] K_LAND    = 7'd36;
    localparam logic [6:0] K_LOR     = 7'd37;
    localparam logic [6:0] K_ASSIGN  = 7'd38;
    localparam logic [6:0] K_ADDEQ   = 7'd39;
    localparam logic [6:0] K_SUBEQ   = 7'd40;
    localparam logic [6:0] K_OREQ    = 7'd41;
    localparam logic [6:0] K_ANDEQ   = 7'd42;
    localparam logic [6:0] K_MULEQ   = 7'd46;
    localparam logic [6:0] K_DIVEQ   = 7'd47;
    localparam logic [6:0] K_MODEQ   = 7'd48;
    localparam logic [6:0] K_ARROW   = 7'd49;
    localparam logic [6:0] K_KW0     = 7'd50;

    // error codes
    localparam logic [3:0] E_NONE       = 4'd0;
    localparam logic [3:0] E_EMPTY_CHAR = 4'd1;
    localparam logic [3:0] E_BAD_CHAR   = 4'd2;
    localparam logic [3:0] E_OPEN_STR   = 4'd3;
    localparam logic [3:0] E_OPEN_CMT   = 4'd4;
    localparam logic [3:0] E_BAD_NUM    = 4'd5;
    localparam logic [3:0] E_UNKNOWN    = 4'd6;
    localparam logic [3:0] E_TOO_LONG   = 4'd7;
    localparam logic [3:0] E_NESTING    = 4'd8;

    localparam int unsigned KW_COUNT = 19;

    // keyword text, first character in the most significant used byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("break"), 64'("case"), 64'("const"), 64'("continue"), 64'("default"),
        64'("do"), 64'("else"), 64'("enum"), 64'("for"), 64'("goto"), 64'("if"),
        64'("return"), 64'("sizeof"), 64'("static"), 64'("struct"), 64'("switch"),
        64'("typedef"), 64'("union"), 64'("while")
    };

    typedef enum logic [13:0] {
        M_IDLE     = 14'b00000000000001,
        M_LINE     = 14'b00000000000010,
        M_OP       = 14'b00000000000100,
        M_NUM_INT  = 14'b00000000001000,
        M_NUM_FLT  = 14'b00000000010000,
        M_IDENT    = 14'b00000000100000,
        M_CH0      = 14'b00000001000000,
        M_CH1      = 14'b00000010000000,
        M_CH2      = 14'b00000100000000,
        M_STR      = 14'b00001000000000,
        M_STR_BS   = 14'b00010000000000,
        M_BC       = 14'b00100000000000,
        M_BC_SLASH = 14'b01000000000000,
        M_BC_STAR  = 14'b10000000000000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [6:0]         token_kind;
        logic signed [31:0] int_value;
        logic [19:0]        span_start;
        logic [8:0]         span_length;
        logic [20:0]        token_line;
        logic [3:0]         error_code;
        logic               is_last;
    } out_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] kind;
    } code_t;

    function automatic logic is_dig(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alp(input logic [7:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
    endfunction

    // bytes that form a token on their own at once
    function automatic code_t punct_code(input logic [7:0] b);
        code_t c;
        c.ok = 1'b1;
        c.kind = K_EOF;
        case (b)
            ":":     c.kind = K_COLON;
            "(":     c.kind = K_LPAREN;
            ")":     c.kind = K_RPAREN;
            "{":     c.kind = K_LBRACE;
            "}":     c.kind = K_RBRACE;
            "[":     c.kind = K_LBRACK;
            "]":     c.kind = K_RBRACK;
            ",":     c.kind = K_COMMA;
            ";":     c.kind = K_SEMI;
            default: c.ok = 1'b0;
        endcase
        return c;
    endfunction

    // operator bytes that are held to look at the next byte: they may start a two-byte operator, a comment or a number
    function automatic code_t single_code(input logic [7:0] b);
        code_t c;
        c.ok = 1'b1;
        c.kind = K_EOF;
        case (b)
            "/":     c.kind = K_SLASH;
            "*":     c.kind = K_STAR;
            "!":     c.kind = K_NOT;
            ">":     c.kind = K_GT;
            "<":     c.kind = K_LT;
            "=":     c.kind = K_ASSIGN;
            "|":     c.kind = K_OROR1;
            "&":     c.kind = K_AND1;
            "%":     c.kind = K_MOD;
            "+":     c.kind = K_PLUS;
            "-":     c.kind = K_MINUS;
            ".":     c.kind = K_DOT;
            default: c.ok = 1'b0;
        endcase
        return c;
    endfunction

    function automatic code_t pair_code(input logic [7:0] a, input logic [7:0] b);
        code_t c;
        c.ok = 1'b1;
        c.kind = K_EOF;
        if (b == "=")
        begin
            case (a)
                "/":     c.kind = K_DIVEQ;
                "*":     c.kind = K_MULEQ;
                "!":     c.kind = K_NE;
                ">":     c.kind = K_GE;
                "<":     c.kind = K_LE;
                "=":     c.kind = K_EQEQ;
                "|":     c.kind = K_OREQ;
                "&":     c.kind = K_ANDEQ;
                "%":     c.kind = K_MODEQ;
                "+":     c.kind = K_ADDEQ;
                "-":     c.kind = K_SUBEQ;
                default: c.ok = 1'b0;
            endcase
        end
        else if (a == "|" && b == "|")
            c.kind = K_LOR;
        else if (a == "&" && b == "&")
            c.kind = K_LAND;
        else if (a == "+" && b == "+")
            c.kind = K_INC;
        else if (a == "-" && b == "-")
            c.kind = K_DEC;
        else if (a == "-" && b == ">")
            c.kind = K_ARROW;
        else
            c.ok = 1'b0;
        return c;
    endfunction

    // identifiers of up to eight bytes are matched whole against the keyword list
    function automatic logic [6:0] kw_lookup(input logic [63:0] text, input logic fits);
        logic [6:0] k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (fits && text == KW_TEXT[i])
                k = K_KW0 + 7'(i);
        end
        return k;
    endfunction

endpackage

/* design/c_subset_tokenizer_top.sv */
// Top level of the streaming C subset tokenizer.
// One source byte (or the end marker) is taken per cycle while in_ready is high and lexed in
// the same cycle; the tokens it completes, at most two, enter a four-entry result queue and
// appear on the output from the next cycle. An item that gives no token or one token sustains
// one item per cycle while out_ready is high; the single-read port of the result queue limits
// output to one token per cycle, so in_ready drops while more than two tokens wait. After the
// first error result no further tokens come out until reset.
module c_subset_tokenizer_top #(
    parameter int unsigned MAX_INPUT_BYTES = csubtok_pkg::MAX_INPUT_BYTES_DEF,
    parameter int unsigned MAX_TOKEN_LEN   = csubtok_pkg::MAX_TOKEN_LEN_DEF,
    parameter int unsigned MAX_NESTING     = csubtok_pkg::MAX_NESTING_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  csubtok_pkg::in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output csubtok_pkg::out_t out_data
);

    logic              wr0, wr1;
    csubtok_pkg::out_t res0, res1;

    csubtok_lex #(
        .MAX_INPUT_BYTES (MAX_INPUT_BYTES),
        .MAX_TOKEN_LEN   (MAX_TOKEN_LEN),
        .MAX_NESTING     (MAX_NESTING)
    ) u_lex (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (in_valid && in_ready),
        .req   (in_data),
        .wr0   (wr0),
        .wr1   (wr1),
        .res0  (res0),
        .res1  (res1)
    );

    csubtok_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr0       (wr0),
        .wr1       (wr1),
        .res0      (res0),
        .res1      (res1),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* design/csubtok_lex.sv */
// Lexer state registers and the combinational step that turns a request into up to two tokens.
module csubtok_lex #(
    parameter int unsigned MAX_INPUT_BYTES = csubtok_pkg::MAX_INPUT_BYTES_DEF,
    parameter int unsigned MAX_TOKEN_LEN   = csubtok_pkg::MAX_TOKEN_LEN_DEF,
    parameter int unsigned MAX_NESTING     = csubtok_pkg::MAX_NESTING_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  csubtok_pkg::in_t  req,
    output logic              wr0,
    output logic              wr1,
    output csubtok_pkg::out_t res0,
    output csubtok_pkg::out_t res1
);

    localparam int unsigned OW  = $clog2(MAX_INPUT_BYTES + 1);
    localparam int unsigned TLW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int unsigned DW  = $clog2(MAX_NESTING + 1);

    typedef struct packed {
        csubtok_pkg::lex_mode_t mode;
        logic [7:0]             held;
        logic [OW-1:0]          offset;
        logic [20:0]            line;
        logic [OW-1:0]          tbegin;
        logic [20:0]            bline;
        logic [TLW-1:0]         tlen;
        logic [31:0]            acc;
        logic                   neg;
        logic [63:0]            kwp;
        logic [DW-1:0]          depth;
        logic                   err;
    } lex_state_t;

    typedef struct packed {
        lex_state_t        ns;
        logic              emit;
        logic              again;
        csubtok_pkg::out_t rec;
    } step_t;

    lex_state_t st_reg, st_next;

    function automatic csubtok_pkg::out_t mk_rec(input logic [6:0] kind,
                                                 input logic [31:0] ival,
                                                 input logic [OW-1:0] start,
                                                 input logic [TLW-1:0] len,
                                                 input logic [20:0] line,
                                                 input logic [3:0] err);
        csubtok_pkg::out_t r;
        r.token_kind  = kind;
        r.int_value   = ival;
        r.span_start  = 20'(start);
        r.span_length = 9'(len);
        r.token_line  = line;
        r.error_code  = err;
        r.is_last     = 1'b0;
        return r;
    endfunction

    function automatic step_t do_fail(input lex_state_t s, input logic [3:0] code);
        step_t r;
        r.ns      = s;
        r.ns.err  = 1'b1;
        r.ns.mode = csubtok_pkg::M_IDLE;
        r.emit    = 1'b1;
        r.again   = 1'b0;
        r.rec     = mk_rec(csubtok_pkg::K_EOF, 32'd0, s.offset, '0, s.line, code);
        return r;
    endfunction

    function automatic step_t lex_handle(input lex_state_t s, input logic eof,
                                         input logic [7:0] b);
        step_t                r;
        logic                 dig;
        logic                 alp;
        csubtok_pkg::code_t   pc;
        csubtok_pkg::code_t   sc;
        csubtok_pkg::code_t   hc;
        csubtok_pkg::code_t   pr;
        logic [35:0]          prod;
        logic [31:0]          ival;
        logic [DW-1:0]        dnew;
        r.ns    = s;
        r.emit  = 1'b0;
        r.again = 1'b0;
        r.rec   = '0;
        dig  = !eof && csubtok_pkg::is_dig(b);
        alp  = !eof && csubtok_pkg::is_alp(b);
        pc   = csubtok_pkg::punct_code(b);
        sc   = csubtok_pkg::single_code(b);
        hc   = csubtok_pkg::single_code(s.held);
        pr   = csubtok_pkg::pair_code(s.held, b);
        prod = {4'd0, s.acc} * 36'd10 + 36'(b - 8'h30);
        ival = '0;
        dnew = s.depth - DW'(1);
        case (s.mode)
            csubtok_pkg::M_IDLE:
            begin
                if (eof)
                begin
                    r.emit = 1'b1;
                    r.rec  = mk_rec(csubtok_pkg::K_EOF, 32'd0, s.offset, '0, s.line,
                                    csubtok_pkg::E_NONE);
                end
                else if (b == " " || b == "\n")
                    r.ns.mode = csubtok_pkg::M_IDLE;
                else if (b == "#")
                    r.ns.mode = csubtok_pkg::M_LINE;
                else if (b == "'" || b == "\"")
                begin
                    r.ns.mode   = (b == "'") ? csubtok_pkg::M_CH0 : csubtok_pkg::M_STR;
                    r.ns.tbegin = s.offset + OW'(1);
                    r.ns.bline  = s.line;
                    r.ns.tlen   = '0;
                end
                else if (pc.ok)
                begin
                    r.emit = 1'b1;
                    r.rec  = mk_rec(pc.kind, 32'd0, s.offset, TLW'(1), s.line,
                                    csubtok_pkg::E_NONE);
                end
                else if (sc.ok || dig || alp)
                begin
                    r.ns.tbegin = s.offset;
                    r.ns.bline  = s.line;
                    r.ns.tlen   = TLW'(1);
                    if (sc.ok)
                    begin
                        r.ns.mode = csubtok_pkg::M_OP;
                        r.ns.held = b;
                    end
                    else if (dig)
                    begin
                        r.ns.mode = csubtok_pkg::M_NUM_INT;
                        r.ns.acc  = 32'(b - 8'h30);
                        r.ns.neg  = 1'b0;
                    end
                    else
                    begin
                        r.ns.mode = csubtok_pkg::M_IDENT;
                        r.ns.kwp  = 64'(b);
                    end
                end
                else
                    r = do_fail(s, csubtok_pkg::E_UNKNOWN);
            end
            csubtok_pkg::M_LINE:
            begin
                if (eof)
                begin
                    r.ns.mode = csubtok_pkg::M_IDLE;
                    r.again   = 1'b1;
                end
                else if (b == "\n")
                    r.ns.mode = csubtok_pkg::M_IDLE;
            end
            csubtok_pkg::M_OP:
            begin
                if (!eof && s.held == "/" && b == "/")
                    r.ns.mode = csubtok_pkg::M_LINE;
                else if (!eof && s.held == "/" && b == "*")
                begin
                    r.ns.depth = DW'(1);
                    r.ns.mode  = csubtok_pkg::M_BC;
                end
                else if (dig && (s.held == "." || s.held == "-"))
                begin
                    r.ns.mode = (s.held == ".") ? csubtok_pkg::M_NUM_FLT
                                                : csubtok_pkg::M_NUM_INT;
                    r.ns.tlen = TLW'(2);
                    r.ns.acc  = (s.held == ".") ? 32'd0 : 32'(b - 8'h30);
                    r.ns.neg  = (s.held == "-");
                end
                else
                begin
                    r.ns.mode = csubtok_pkg::M_IDLE;
                    r.emit    = 1'b1;
                    if (!eof && pr.ok)
                        r.rec = mk_rec(pr.kind, 32'd0, s.tbegin, TLW'(2), s.bline,
                                       csubtok_pkg::E_NONE);
                    else
                    begin
                        r.rec   = mk_rec(hc.kind, 32'd0, s.tbegin, TLW'(1), s.bline,
                                         csubtok_pkg::E_NONE);
                        r.again = 1'b1;
                    end
                end
            end
            csubtok_pkg::M_NUM_INT, csubtok_pkg::M_NUM_FLT:
            begin
                if (dig || (!eof && b == "."))
                begin
                    if (b == "." && s.mode == csubtok_pkg::M_NUM_FLT)
                        r = do_fail(s, csubtok_pkg::E_BAD_NUM);
                    else if (s.tlen >= TLW'(MAX_TOKEN_LEN))
                        r = do_fail(s, csubtok_pkg::E_TOO_LONG);
                    else
                    begin
                        r.ns.tlen = s.tlen + TLW'(1);
                        if (b == ".")
                            r.ns.mode = csubtok_pkg::M_NUM_FLT;
                        else
                            r.ns.acc = (prod > 36'h080000000) ? 32'h80000000 : prod[31:0];
                    end
                end
                else
                begin
                    if (s.mode == csubtok_pkg::M_NUM_INT)
                    begin
                        if (s.neg)
                            ival = 32'd0 - s.acc;
                        else
                            ival = (s.acc > 32'h7FFFFFFF) ? 32'h7FFFFFFF : s.acc;
                    end
                    r.emit    = 1'b1;
                    r.again   = 1'b1;
                    r.ns.mode = csubtok_pkg::M_IDLE;
                    r.rec     = mk_rec((s.mode == csubtok_pkg::M_NUM_INT) ?
                                       csubtok_pkg::K_INT : csubtok_pkg::K_FLOAT,
                                       ival, s.tbegin, s.tlen, s.bline,
                                       csubtok_pkg::E_NONE);
                end
            end
            csubtok_pkg::M_IDENT:
            begin
                if (dig || alp)
                begin
                    if (s.tlen >= TLW'(MAX_TOKEN_LEN))
                        r = do_fail(s, csubtok_pkg::E_TOO_LONG);
                    else
                    begin
                        if (s.tlen < TLW'(8))
                            r.ns.kwp = {s.kwp[55:0], b};
                        r.ns.tlen = s.tlen + TLW'(1);
                    end
                end
                else
                begin
                    r.emit    = 1'b1;
                    r.again   = 1'b1;
                    r.ns.mode = csubtok_pkg::M_IDLE;
                    r.rec     = mk_rec(csubtok_pkg::kw_lookup(s.kwp, s.tlen <= TLW'(8)),
                                       32'd0, s.tbegin, s.tlen, s.bline,
                                       csubtok_pkg::E_NONE);
                end
            end
            csubtok_pkg::M_CH0:
            begin
                if (!eof && b == "'")
                    r = do_fail(s, csubtok_pkg::E_EMPTY_CHAR);
                else if (eof)
                    r = do_fail(s, csubtok_pkg::E_BAD_CHAR);
                else
                begin
                    r.ns.held = b;
                    r.ns.mode = csubtok_pkg::M_CH1;
                end
            end
            csubtok_pkg::M_CH1:
            begin
                if (eof)
                    r = do_fail(s, csubtok_pkg::E_BAD_CHAR);
                else if (s.held == "\\")
                begin
                    r.ns.held = b;
                    r.ns.mode = csubtok_pkg::M_CH2;
                end
                else if (b == "'")
                begin
                    r.emit    = 1'b1;
                    r.ns.mode = csubtok_pkg::M_IDLE;
                    r.rec     = mk_rec(csubtok_pkg::K_CHAR, 32'd0, s.tbegin, TLW'(1),
                                       s.bline, csubtok_pkg::E_NONE);
                end
                else
                    r = do_fail(s, csubtok_pkg::E_BAD_CHAR);
            end
            csubtok_pkg::M_CH2:
            begin
                // an escaped quote followed by a non-quote is a one-byte char; relex the byte
                if ((!eof && b == "'") || s.held == "'")
                begin
                    r.emit    = 1'b1;
                    r.again   = !(!eof && b == "'");
                    r.ns.mode = csubtok_pkg::M_IDLE;
                    r.rec     = mk_rec(csubtok_pkg::K_CHAR, 32'd0, s.tbegin,
                                       (!eof && b == "'") ? TLW'(2) : TLW'(1),
                                       s.bline, csubtok_pkg::E_NONE);
                end
                else
                    r = do_fail(s, csubtok_pkg::E_BAD_CHAR);
            end
            csubtok_pkg::M_STR, csubtok_pkg::M_STR_BS:
            begin
                if (eof)
                    r = do_fail(s, csubtok_pkg::E_OPEN_STR);
                else if (b == "\"" && s.mode == csubtok_pkg::M_STR)
                begin
                    r.emit    = 1'b1;
                    r.ns.mode = csubtok_pkg::M_IDLE;
                    r.rec     = mk_rec(csubtok_pkg::K_STR, 32'd0, s.tbegin, s.tlen,
                                       s.bline, csubtok_pkg::E_NONE);
                end
                else
                begin
                    if (s.tlen < TLW'(MAX_TOKEN_LEN))
                        r.ns.tlen = s.tlen + TLW'(1);
                    r.ns.mode = (b == "\\") ? csubtok_pkg::M_STR_BS : csubtok_pkg::M_STR;
                end
            end
            csubtok_pkg::M_BC, csubtok_pkg::M_BC_SLASH, csubtok_pkg::M_BC_STAR:
            begin
                if (eof)
                    r = do_fail(s, csubtok_pkg::E_OPEN_CMT);
                else if (s.mode == csubtok_pkg::M_BC_SLASH && b == "*")
                begin
                    if (s.depth >= DW'(MAX_NESTING))
                        r = do_fail(s, csubtok_pkg::E_NESTING);
                    else
                    begin
                        r.ns.depth = s.depth + DW'(1);
                        r.ns.mode  = csubtok_pkg::M_BC;
                    end
                end
                else if (s.mode == csubtok_pkg::M_BC_STAR && b == "/")
                begin
                    if (s.depth == '0)
                        dnew = '0;
                    r.ns.depth = dnew;
                    r.ns.mode  = (dnew != '0) ? csubtok_pkg::M_BC : csubtok_pkg::M_IDLE;
                end
                else
                    r.ns.mode = (b == "/") ? csubtok_pkg::M_BC_SLASH :
                                (b == "*") ? csubtok_pkg::M_BC_STAR : csubtok_pkg::M_BC;
            end
            default:
                r.ns.mode = csubtok_pkg::M_IDLE;
        endcase
        return r;
    endfunction

    step_t p1, p2;
    logic  run2;

    always_comb
    begin
        p1      = lex_handle(st_reg, req.end_of_input, req.byte_value);
        run2    = p1.again && !p1.ns.err;
        p2      = lex_handle(p1.ns, req.end_of_input, req.byte_value);
        st_next = st_reg;
        wr0     = 1'b0;
        wr1     = 1'b0;
        res0    = p1.rec;
        res1    = p2.rec;
        if (take && !st_reg.err)
        begin
            if (!req.end_of_input && st_reg.offset >= OW'(MAX_INPUT_BYTES))
            begin
                p1      = do_fail(st_reg, csubtok_pkg::E_TOO_LONG);
                run2    = 1'b0;
                st_next = p1.ns;
                res0    = p1.rec;
            end
            else
            begin
                st_next = run2 ? p2.ns : p1.ns;
                if (p1.emit)
                begin
                    wr1 = run2 && p2.emit;
                end
                else
                    res0 = p2.rec;
                if (!req.end_of_input)
                begin
                    if (req.byte_value == "\n" && st_next.line < csubtok_pkg::LINE_MAX)
                        st_next.line = st_next.line + 21'd1;
                    st_next.offset = st_next.offset + OW'(1);
                end
            end
            wr0 = p1.emit || (run2 && p2.emit);
        end
        res0.is_last = !wr1;
        res1.is_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{mode: csubtok_pkg::M_IDLE, held: '0, offset: '0, line: 21'd1,
                        tbegin: '0, bline: 21'd1, tlen: '0, acc: '0, neg: 1'b0,
                        kwp: '0, depth: '0, err: 1'b0};
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

/* design/csubtok_outq.sv */
// Four-entry result queue taking up to two tokens a cycle and handing out one while out_ready is high.
module csubtok_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr0,
    input  logic              wr1,
    input  csubtok_pkg::out_t res0,
    input  csubtok_pkg::out_t res1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output csubtok_pkg::out_t out_data
);

    csubtok_pkg::out_t mem_reg [4];
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       rd;

    assign room      = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem_reg[rp_reg];
    assign rd        = out_valid && out_ready;

    always_comb
    begin
        wp_next  = wp_reg + 2'(wr0) + 2'(wr1);
        rp_next  = rp_reg + 2'(rd);
        cnt_next = cnt_reg + 3'(wr0) + 3'(wr1) - 3'(rd);
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
            mem_reg[wp_reg] <= res0;
        if (wr1)
            mem_reg[wp_reg + 2'd1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* design/csubtok_chk.sv */
// Port-level checks for the tokenizer, bound to the top level.
module csubtok_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input csubtok_pkg::out_t out_data
);

    // a stalled token holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled token dropped or changed");

    // lines count from one
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.token_line != 21'd0)
        else $error("token line zero");

    // an error or end token closes the results of its request and carries no text
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.token_kind == csubtok_pkg::K_EOF |->
            out_data.is_last && out_data.span_length == 9'd0 && out_data.int_value == 32'sd0)
        else $error("bad end or error token");

    // errors only come as end-kind tokens
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != csubtok_pkg::E_NONE |->
            out_data.token_kind == csubtok_pkg::K_EOF)
        else $error("error on a non-end token");

endmodule

bind c_subset_tokenizer_top csubtok_chk u_chk (.*);
